### rtl/fdm_pkg.sv
package fdm_pkg;

    // Port widths
    localparam int FUNC_W     = 3;
    localparam int VALUE_W    = 8;
    localparam int DUTY_W     = 16;
    localparam int PMIC_LO_W  = 8;
    localparam int PMIC_HI_W  = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // Internal widths
    localparam int PCT_W      = 7;
    localparam int LVL_W      = 8;
    localparam int LVL_SQ_W   = 16;
    localparam int PMIC_D_W   = 12;
    localparam int UPD_W      = 15;
    localparam int UPD_RCP_W  = 16;
    localparam int PMIC_XW    = 26;
    localparam int PMIC_RW    = 27;

    // Command codes
    localparam logic [FUNC_W-1:0] FUNC_SET_PCT  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_SET_LVL  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_OFF      = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_ON       = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_SET_WARM = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PWM_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DUAL        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HIGH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PMIC        = 2'd3;

    localparam logic [CFG_DATA_W-1:0] PWM_BITS_RST = 5'd8;
    localparam logic [PCT_W-1:0]      PCT_MAX      = 7'd100;
    localparam logic [LVL_W-1:0]      LVL_MAX      = 8'd255;
    localparam logic [PCT_W-1:0]      ROUND_HALF   = 7'd50;
    localparam logic [LVL_SQ_W-1:0]   LVL_DIV      = 16'd64516;

    // Reciprocals: floor(x / d) == (x * ceil(2^k / d)) >> k over the range in use
    localparam int UPD_K_LVL = 22;
    localparam int UPD_K_PCT = 23;
    localparam int PMIC_K    = 40;
    localparam logic [UPD_RCP_W-1:0] RCP_100_UPD =
        UPD_RCP_W'(((64'd1 << UPD_K_LVL) + 64'd99) / 64'd100);
    localparam logic [UPD_RCP_W-1:0] RCP_255 =
        UPD_RCP_W'(((64'd1 << UPD_K_PCT) + 64'd254) / 64'd255);
    localparam logic [PMIC_RW-1:0] RCP_10000 =
        PMIC_RW'(((64'd1 << PMIC_K) + 64'd9999) / 64'd10000);

    typedef enum logic [3:0] {
        OP_NONE,
        OP_UPD_MUL,
        OP_UPD_WR,
        OP_SQUARE,
        OP_SCALE,
        OP_PCT_DIV,
        OP_PCT_TOT,
        OP_DIV_GO,
        OP_LVL_TOT,
        OP_WARM_MUL,
        OP_WARM_DIV,
        OP_OUT
    } t_dp_op;

    typedef struct packed {
        logic   load;
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic pmic_mode;
        logic level_mode;
        logic dual_channel;
        logic div_done;
    } t_dp_stat;

endpackage

### rtl/fdm_div.sv
module fdm_div
    import fdm_pkg::*;
#(
    parameter int NW = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_dividend,
    output logic [NW-1:0] o_quotient,
    output logic          o_done
);

    // 254 squared is four times an odd number: drop the factor of four by a shift,
    // then divide by the odd part with a reciprocal that is exact below 2^(NW-2)
    localparam logic [LVL_SQ_W-1:0] ODD_DIV = LVL_DIV >> 2;
    localparam int YW = NW - 2;
    localparam int K  = NW + 12;
    localparam int MW = NW - 1;
    localparam int PW = YW + MW;
    localparam logic [MW-1:0] RCP =
        MW'(((64'd1 << K) + 64'(ODD_DIV) - 64'd1) / 64'(ODD_DIV));

    logic [YW-1:0] y;
    logic [PW-1:0] r_prod;
    logic          r_done;

    assign y = i_dividend[NW-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
        end
    end

    // One multiply per start; hold the product until the next start
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod <= PW'(y) * PW'(RCP);
        end
    end

    assign o_quotient = NW'(r_prod[PW-1:K]);
    assign o_done     = r_done;

    a_done_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> o_done)
        else $error("divider start without done");

    a_done_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start))
        else $error("divider done without a start");

    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> !i_start)
        else $error("divider restarted while its result is pending");

endmodule

### rtl/fdm_dp.sv
module fdm_dp
    import fdm_pkg::*;
#(
    parameter int MAX_PWM_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [FUNC_W-1:0]     i_func,
    input  logic [VALUE_W-1:0]    i_value,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    output logic [DUTY_W-1:0]     o_cool_duty,
    output logic [DUTY_W-1:0]     o_warm_duty,
    output logic [PMIC_LO_W-1:0]  o_pmic_duty_low,
    output logic [PMIC_HI_W-1:0]  o_pmic_duty_high
);

    localparam int FW   = MAX_PWM_BITS;
    localparam int XW   = FW + 7;
    localparam int K100 = XW + 7;
    localparam int RW   = XW + 1;
    localparam int LXW  = LVL_SQ_W + FW;
    localparam int MA   = (XW > PMIC_XW) ? XW : PMIC_XW;
    localparam int MB   = (RW > PMIC_RW) ? RW : PMIC_RW;
    localparam int PW   = MA + MB;

    localparam logic [RW-1:0] RCP_100 = RW'(((64'd1 << K100) + 64'd99) / 64'd100);
    localparam logic [CFG_DATA_W-1:0] BITS_MAX = CFG_DATA_W'(FW);

    // Configuration
    logic [CFG_DATA_W-1:0] r_pwm_bits;
    logic                  r_dual;
    logic                  r_active_high;
    logic                  r_pmic;

    // Brightness state
    logic [PCT_W-1:0] r_pct;
    logic [LVL_W-1:0] r_lvl;
    logic             r_lvl_mode;
    logic [PCT_W-1:0] r_last;
    logic [PCT_W-1:0] r_warm_share;

    // Working registers
    logic [FUNC_W-1:0]    r_func;
    logic [VALUE_W-1:0]   r_value;
    logic [PW-1:0]        r_prod;
    logic [FW-1:0]        r_total;
    logic [DUTY_W-1:0]    r_cool;
    logic [DUTY_W-1:0]    r_warm;
    logic [PMIC_LO_W-1:0] r_plo;
    logic [PMIC_HI_W-1:0] r_phi;

    logic [PCT_W-1:0]      value_clamp;
    logic [PCT_W-1:0]      p_sel;
    logic [UPD_W-1:0]      upd_a;
    logic [UPD_RCP_W-1:0]  upd_b;
    logic [LVL_W-1:0]      sq_op;
    logic [PMIC_XW-1:0]    pmic_x;
    logic [CFG_DATA_W-1:0] bits_c;
    logic [FW-1:0]         ones_fw;
    logic [FW-1:0]         full;
    logic [FW-1:0]         full_m1;
    logic [XW-1:0]         num_rnd;
    logic [MA-1:0]         mul_a;
    logic [MB-1:0]         mul_b;
    logic [PW-1:0]         prod;
    logic [LVL_W-1:0]      lvl_from_pct;
    logic [PCT_W-1:0]      pct_from_lvl;
    logic [PMIC_D_W-1:0]   pmic_d;
    logic [FW-1:0]         q100;
    logic [LXW-1:0]        quo;
    logic                  div_done;
    logic [FW-1:0]         warm_l;
    logic [FW-1:0]         cool_l;
    logic [FW-1:0]         cool_p;
    logic [FW-1:0]         warm_p;

    assign value_clamp = (r_value > VALUE_W'(PCT_MAX)) ? PCT_MAX : r_value[PCT_W-1:0];

    always_comb begin
        case (r_func)
            FUNC_OFF: p_sel = '0;
            FUNC_ON:  p_sel = r_last;
            default:  p_sel = value_clamp;
        endcase
    end

    always_comb begin
        if (r_func == FUNC_SET_LVL) begin
            upd_a = UPD_W'(r_value) * UPD_W'(PCT_MAX);
            upd_b = RCP_255;
        end else begin
            upd_a = UPD_W'(p_sel) * UPD_W'(LVL_MAX);
            upd_b = RCP_100_UPD;
        end
    end

    assign sq_op  = r_pmic ? LVL_W'(r_pct) : (r_lvl - LVL_W'(1));
    assign pmic_x = (PMIC_XW'(r_prod[13:0]) << PMIC_D_W) - PMIC_XW'(r_prod[13:0]);

    assign bits_c = (r_pwm_bits == '0) ? CFG_DATA_W'(1) :
                    (r_pwm_bits > BITS_MAX) ? BITS_MAX : r_pwm_bits;
    assign ones_fw = '1;
    assign full    = ones_fw >> (BITS_MAX - bits_c);
    assign full_m1 = full - FW'(1);
    assign num_rnd = r_prod[XW-1:0] + XW'(ROUND_HALF);

    // Shared multiplier; each product is registered before the next use
    always_comb begin
        case (i_cmd.op)
            OP_UPD_MUL: begin
                mul_a = MA'(upd_a);
                mul_b = MB'(upd_b);
            end
            OP_SQUARE: begin
                mul_a = MA'(sq_op);
                mul_b = MB'(sq_op);
            end
            OP_SCALE: begin
                if (r_pmic) begin
                    mul_a = MA'(pmic_x);
                    mul_b = MB'(RCP_10000);
                end else if (r_lvl_mode) begin
                    mul_a = MA'(r_prod[LVL_SQ_W-1:0]);
                    mul_b = MB'(full_m1);
                end else begin
                    mul_a = MA'(r_pct);
                    mul_b = MB'(full);
                end
            end
            OP_PCT_DIV, OP_WARM_DIV: begin
                mul_a = MA'(num_rnd);
                mul_b = MB'(RCP_100);
            end
            OP_WARM_MUL: begin
                mul_a = MA'(r_total);
                mul_b = MB'(r_warm_share);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = PW'(mul_a) * PW'(mul_b);

    assign lvl_from_pct = r_prod[UPD_K_LVL +: LVL_W];
    assign pct_from_lvl = r_prod[UPD_K_PCT +: PCT_W];
    assign pmic_d       = r_prod[PMIC_K +: PMIC_D_W];
    assign q100         = r_prod[K100 +: FW];

    fdm_div #(
        .NW (LXW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.op == OP_DIV_GO),
        .i_dividend (r_prod[LXW-1:0]),
        .o_quotient (quo),
        .o_done     (div_done)
    );

    assign warm_l = r_dual ? q100 : '0;
    assign cool_l = r_total - warm_l;
    assign cool_p = r_active_high ? cool_l : (full - cool_l);
    assign warm_p = r_dual ? (r_active_high ? warm_l : (full - warm_l)) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_bits    <= PWM_BITS_RST;
            r_dual        <= 1'b0;
            r_active_high <= 1'b1;
            r_pmic        <= 1'b0;
            r_pct         <= '0;
            r_lvl         <= '0;
            r_lvl_mode    <= 1'b0;
            r_last        <= PCT_MAX;
            r_warm_share  <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_PWM_BITS:    r_pwm_bits    <= i_cfg_data;
                    REG_DUAL:        r_dual        <= i_cfg_data[0];
                    REG_ACTIVE_HIGH: r_active_high <= i_cfg_data[0];
                    REG_PMIC:        r_pmic        <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.op == OP_UPD_WR) begin
                case (r_func)
                    FUNC_SET_PCT, FUNC_OFF, FUNC_ON: begin
                        r_pct      <= p_sel;
                        r_lvl      <= lvl_from_pct;
                        r_lvl_mode <= 1'b0;
                        if (p_sel != '0) begin
                            r_last <= p_sel;
                        end
                    end
                    FUNC_SET_LVL: begin
                        r_lvl      <= r_value;
                        r_pct      <= pct_from_lvl;
                        r_lvl_mode <= 1'b1;
                    end
                    FUNC_SET_WARM: r_warm_share <= value_clamp;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= i_func;
            r_value <= i_value;
        end
        case (i_cmd.op)
            OP_UPD_MUL, OP_SQUARE, OP_SCALE, OP_PCT_DIV, OP_WARM_MUL, OP_WARM_DIV: begin
                r_prod <= prod;
            end
            OP_PCT_TOT: r_total <= q100;
            // Level zero gives no light at all
            OP_LVL_TOT: r_total <= (r_lvl == '0) ? '0 : (quo[FW-1:0] + FW'(1));
            OP_OUT: begin
                if (r_pmic) begin
                    r_cool <= '0;
                    r_warm <= '0;
                    r_plo  <= pmic_d[PMIC_LO_W-1:0];
                    r_phi  <= {(pmic_d != '0), pmic_d[PMIC_D_W-1:PMIC_LO_W]};
                end else begin
                    r_cool <= DUTY_W'(cool_p);
                    r_warm <= DUTY_W'(warm_p);
                    r_plo  <= '0;
                    r_phi  <= '0;
                end
            end
            default: ;
        endcase
    end

    assign o_stat.pmic_mode    = r_pmic;
    assign o_stat.level_mode   = r_lvl_mode;
    assign o_stat.dual_channel = r_dual;
    assign o_stat.div_done     = div_done;

    assign o_cool_duty      = r_cool;
    assign o_warm_duty      = r_warm;
    assign o_pmic_duty_low  = r_plo;
    assign o_pmic_duty_high = r_phi;

endmodule

### rtl/fdm_ctrl.sv
module fdm_ctrl
    import fdm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_UPD_MUL,
        S_UPD_WR,
        S_SQUARE,
        S_SCALE,
        S_PCT_DIV,
        S_PCT_TOT,
        S_DIV_GO,
        S_DIV_WAIT,
        S_LVL_TOT,
        S_WARM_MUL,
        S_WARM_DIV,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   slot_free;

    assign slot_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state    = r_state;
        o_cmd.load = (r_state == S_IDLE) && i_in_valid;
        o_cmd.op   = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_UPD_MUL;
                end
            end
            S_UPD_MUL: begin
                o_cmd.op = OP_UPD_MUL;
                n_state  = S_UPD_WR;
            end
            S_UPD_WR: begin
                o_cmd.op = OP_UPD_WR;
                n_state  = S_SQUARE;
            end
            S_SQUARE: begin
                o_cmd.op = OP_SQUARE;
                n_state  = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.op = OP_SCALE;
                if (i_stat.pmic_mode) begin
                    n_state = S_OUT;
                end else if (i_stat.level_mode) begin
                    n_state = S_DIV_GO;
                end else begin
                    n_state = S_PCT_DIV;
                end
            end
            S_PCT_DIV: begin
                o_cmd.op = OP_PCT_DIV;
                n_state  = S_PCT_TOT;
            end
            S_PCT_TOT: begin
                o_cmd.op = OP_PCT_TOT;
                n_state  = i_stat.dual_channel ? S_WARM_MUL : S_OUT;
            end
            S_DIV_GO: begin
                o_cmd.op = OP_DIV_GO;
                n_state  = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_LVL_TOT;
                end
            end
            S_LVL_TOT: begin
                o_cmd.op = OP_LVL_TOT;
                n_state  = i_stat.dual_channel ? S_WARM_MUL : S_OUT;
            end
            S_WARM_MUL: begin
                o_cmd.op = OP_WARM_MUL;
                n_state  = S_WARM_DIV;
            end
            S_WARM_DIV: begin
                o_cmd.op = OP_WARM_DIV;
                n_state  = S_OUT;
            end
            S_OUT: begin
                // hold until the output register is free
                if (slot_free) begin
                    o_cmd.op = OP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    a_stall_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after an accepted transaction");

    a_valid_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_OUT))
        else $error("result raised outside the output step");

    a_div_only_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV_WAIT) |-> (i_stat.level_mode && !i_stat.pmic_mode))
        else $error("divider wait outside level mode");

endmodule

### rtl/frontlight_duty_mixer_core.sv
// An accepted input transaction steps through UPD_MUL, UPD_WR, SQUARE and SCALE, then OUT in
// PMIC mode; percent mode adds PCT_DIV and PCT_TOT, level mode DIV_GO, DIV_WAIT and LVL_TOT,
// and the warm channel adds WARM_MUL and WARM_DIV. The output register frees the input side.
// OUT registers the result, and a new transaction is accepted back in idle. The sequence comes
// from the one shared multiplier and, in level mode, the reciprocal multiply that divides by 254 squared.
// Synchronous active-low reset returns the sequencer, configuration and brightness state to their reset values.
module frontlight_duty_mixer_core
    import fdm_pkg::*;
#(
    parameter int MAX_PWM_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [FUNC_W-1:0]     i_func,
    input  logic [VALUE_W-1:0]    i_value,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [DUTY_W-1:0]     o_cool_duty,
    output logic [DUTY_W-1:0]     o_warm_duty,
    output logic [PMIC_LO_W-1:0]  o_pmic_duty_low,
    output logic [PMIC_HI_W-1:0]  o_pmic_duty_high
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    fdm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    fdm_dp #(
        .MAX_PWM_BITS (MAX_PWM_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_func           (i_func),
        .i_value          (i_value),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_cool_duty      (o_cool_duty),
        .o_warm_duty      (o_warm_duty),
        .o_pmic_duty_low  (o_pmic_duty_low),
        .o_pmic_duty_high (o_pmic_duty_high)
    );

endmodule
